// ===== hdl/ssl_pkg.sv =====
// package for the stanley steering law block
// constants, item types and the cordic arctangent table; no dependencies
`timescale 1ns / 1ps

package ssl_pkg;

	// fixed point constants
	localparam int CORDIC_ITERATIONS_DEF = 16;
	localparam int CORDIC_TABLE_LEN      = 24;
	localparam int QUEUE_DEPTH           = 4;
	localparam int QPTR_W                = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W                = $clog2(QUEUE_DEPTH + 1);

	localparam logic signed [27:0] PI_Q24      = 28'sd52707179;
	localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
	localparam logic signed [16:0] PI_Q13      = 17'sd25736;
	localparam logic signed [16:0] TWO_PI_Q13  = 17'sd51472;
	localparam logic signed [31:0] CORDIC_K_Q30 = 32'sd652032874;
	localparam logic signed [58:0] EY_MAX = 59'sd8388607;
	localparam logic signed [58:0] EY_MIN = -59'sd8388608;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'd1;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] GAIN_RESET  = 16'd3277;
	localparam logic [14:0] LIMIT_RESET = 15'd8192;

	// classified item between front and back
	typedef struct packed {
		logic signed [24:0] dx;
		logic signed [24:0] dy;
		logic signed [16:0] eh;
		logic signed [27:0] z;
		logic               neg;
		logic        [15:0] spd;
	} ssl_item_t;

	// queue status seen by the front
	typedef struct packed {
		logic full;
		logic empty;
	} ssl_q_status_t;

	// atan(2^-i) in q.24 radians
	function automatic logic [23:0] atan_q24(input int i);
		logic [23:0] v;
		case (i)
			0: v = 24'd13176795;
			1: v = 24'd7778716;
			2: v = 24'd4110060;
			3: v = 24'd2086331;
			4: v = 24'd1047214;
			5: v = 24'd524117;
			6: v = 24'd262123;
			7: v = 24'd131069;
			8: v = 24'd65536;
			9: v = 24'd32768;
			10: v = 24'd16384;
			11: v = 24'd8192;
			12: v = 24'd4096;
			13: v = 24'd2048;
			14: v = 24'd1024;
			15: v = 24'd512;
			16: v = 24'd256;
			17: v = 24'd128;
			18: v = 24'd64;
			19: v = 24'd32;
			20: v = 24'd16;
			21: v = 24'd8;
			22: v = 24'd4;
			23: v = 24'd2;
			default: v = 24'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/ssl_if.sv =====
// valid/ready channel interfaces for pose items and steering results
// depends on nothing but the handshake convention
`timescale 1ns / 1ps

interface ssl_pose_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] ref_x;
	logic signed [23:0] ref_y;
	logic signed [15:0] ref_heading;
	logic signed [23:0] vehicle_x;
	logic signed [23:0] vehicle_y;
	logic signed [15:0] vehicle_heading;
	logic        [15:0] vehicle_speed;

	modport source (output valid, output ref_x, output ref_y, output ref_heading,
		output vehicle_x, output vehicle_y, output vehicle_heading,
		output vehicle_speed, input ready);
	modport sink (input valid, input ref_x, input ref_y, input ref_heading,
		input vehicle_x, input vehicle_y, input vehicle_heading,
		input vehicle_speed, output ready);
endinterface

interface ssl_steer_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] steer_angle;
	logic               steer_clamped;

	modport source (output valid, output steer_angle, output steer_clamped, input ready);
	modport sink (input valid, input steer_angle, input steer_clamped, output ready);
endinterface

// ===== hdl/ssl_front.sv =====
// front stage: accepts pose transactions, forms differences and wraps angles
// depends on ssl_pkg and ssl_pose_if
`timescale 1ns / 1ps

module ssl_front (
	input  logic                   clk,
	input  logic                   arst_n,
	ssl_pose_if.sink               pose,
	input  ssl_pkg::ssl_q_status_t qstat,
	output logic                   push,
	output ssl_pkg::ssl_item_t     item
);

	logic               valid_s1;
	ssl_pkg::ssl_item_t item_s1;
	ssl_pkg::ssl_item_t item_c;
	logic signed [16:0] eh_raw;
	logic signed [16:0] eh_hi;
	logic signed [27:0] ang;

	// accept while the held transaction can drain into the queue
	assign pose.ready = !valid_s1 || !qstat.full;
	assign push       = valid_s1 && !qstat.full;
	assign item       = item_s1;

	// position differences, heading error wrap and angle fold
	always_comb begin
		item_c.dx  = 25'(pose.ref_x) - 25'(pose.vehicle_x);
		item_c.dy  = 25'(pose.ref_y) - 25'(pose.vehicle_y);
		item_c.spd = pose.vehicle_speed;
		eh_raw = 17'(pose.ref_heading) - 17'(pose.vehicle_heading);
		eh_hi  = (eh_raw > ssl_pkg::PI_Q13) ? eh_raw - ssl_pkg::TWO_PI_Q13 : eh_raw;
		item_c.eh = (eh_hi < -ssl_pkg::PI_Q13) ? eh_hi + ssl_pkg::TWO_PI_Q13 : eh_hi;
		ang = $signed({pose.ref_heading[15], pose.ref_heading, 11'd0});
		if (ang > ssl_pkg::HALF_PI_Q24) begin
			item_c.z   = ang - ssl_pkg::PI_Q24;
			item_c.neg = 1'b1;
		end else if (ang < -ssl_pkg::HALF_PI_Q24) begin
			item_c.z   = ang + ssl_pkg::PI_Q24;
			item_c.neg = 1'b1;
		end else begin
			item_c.z   = ang;
			item_c.neg = 1'b0;
		end
	end

	// front register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pose.ready) begin
			valid_s1 <= pose.valid;
		end
	end

	// front register payload
	always_ff @(posedge clk) begin
		if (pose.ready && pose.valid) begin
			item_s1 <= item_c;
		end
	end

endmodule

// ===== hdl/ssl_queue.sv =====
// short queue between front and back stages
// depends on ssl_pkg
`timescale 1ns / 1ps

module ssl_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  ssl_pkg::ssl_item_t     push_item,
	input  logic                   pop,
	output ssl_pkg::ssl_item_t     head,
	output ssl_pkg::ssl_q_status_t qstat
);

	ssl_pkg::ssl_item_t              slot_q [0:ssl_pkg::QUEUE_DEPTH-1];
	logic [ssl_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [ssl_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [ssl_pkg::QCNT_W-1:0]      count_q;
	logic                            do_push;
	logic                            do_pop;

	assign qstat.full  = (count_q == ssl_pkg::QCNT_W'(ssl_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push = push && !qstat.full;
	assign do_pop  = pop && !qstat.empty;
	assign head    = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ssl_pkg::QCNT_W'(ssl_pkg::QUEUE_DEPTH))
		else $error("queue fill count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty && !push |=> qstat.empty || push)
		else $error("queue lost track of empty state");

endmodule

// ===== hdl/ssl_back.sv =====
// back pipeline: cordic sin/cos, cross-track error, cordic atan2 and clamp
// depends on ssl_pkg and ssl_steer_if
`timescale 1ns / 1ps

module ssl_back #(
	parameter int CORDIC_ITERATIONS = ssl_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  ssl_pkg::ssl_item_t head,
	output logic               pop,
	input  logic        [15:0] gain,
	input  logic        [14:0] limit,
	ssl_steer_if.source        steer
);

	localparam int N = CORDIC_ITERATIONS;

	logic en;

	// sin/cos cordic stages
	logic                      sc_v_s [0:N];
	logic signed [31:0]        sc_x_s [0:N];
	logic signed [31:0]        sc_y_s [0:N];
	logic signed [28:0]        sc_z_s [0:N];
	ssl_pkg::ssl_item_t        sc_it_s [0:N];

	// sign fix, product, error and numerator stages
	logic                      v_s1, v_s2, v_s3, v_s4;
	logic signed [31:0]        sin_s1, cos_s1;
	logic signed [24:0]        dx_s1, dy_s1;
	logic signed [56:0]        pc_s2, ps_s2;
	logic signed [23:0]        ey_s3;
	logic signed [16:0]        eh_s1, eh_s2, eh_s3, eh_s4;
	logic        [15:0]        spd_s1, spd_s2, spd_s3, spd_s4;
	logic signed [40:0]        num_s4;
	logic signed [58:0]        ey_sum;
	logic signed [58:0]        ey_shr;
	logic signed [23:0]        ey_c;
	logic signed [40:0]        num_c;

	// atan2 cordic stages
	logic                      at_v_s [0:N];
	logic signed [41:0]        at_x_s [0:N];
	logic signed [41:0]        at_y_s [0:N];
	logic signed [27:0]        at_z_s [0:N];
	logic signed [16:0]        at_eh_s [0:N];
	logic                      at_d0_s [0:N];
	logic                      at_np_s [0:N];
	logic                      at_nn_s [0:N];

	// output register
	logic                      out_valid_q;
	logic signed [15:0]        steer_q;
	logic                      clamp_q;
	logic signed [27:0]        at_fin;
	logic signed [28:0]        at_rnd;
	logic signed [18:0]        steer_raw;
	logic signed [18:0]        lim19;
	logic signed [15:0]        steer_c;
	logic                      clamp_c;

	// whole pipeline advances unless the result register is stalled
	assign en  = !out_valid_q || steer.ready;
	assign pop = en && q_valid;

	assign steer.valid         = out_valid_q;
	assign steer.steer_angle   = steer_q;
	assign steer.steer_clamped = clamp_q;

	// sin/cos cordic entry from queue head
	assign sc_v_s[0]  = q_valid;
	assign sc_x_s[0]  = ssl_pkg::CORDIC_K_Q30;
	assign sc_y_s[0]  = '0;
	assign sc_z_s[0]  = 29'(head.z);
	assign sc_it_s[0] = head;

	for (genvar g = 0; g < N; g++) begin : g_sc
		localparam logic signed [28:0] ATAN_C = $signed({5'd0, ssl_pkg::atan_q24(g)});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sc_v_s[g+1] <= 1'b0;
			end else if (en) begin
				sc_v_s[g+1] <= sc_v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sc_it_s[g+1] <= sc_it_s[g];
				if (sc_z_s[g] >= 0) begin
					sc_x_s[g+1] <= sc_x_s[g] - (sc_y_s[g] >>> g);
					sc_y_s[g+1] <= sc_y_s[g] + (sc_x_s[g] >>> g);
					sc_z_s[g+1] <= sc_z_s[g] - ATAN_C;
				end else begin
					sc_x_s[g+1] <= sc_x_s[g] + (sc_y_s[g] >>> g);
					sc_y_s[g+1] <= sc_y_s[g] - (sc_x_s[g] >>> g);
					sc_z_s[g+1] <= sc_z_s[g] + ATAN_C;
				end
			end
		end
	end

	// cross-track error rounding and saturation
	always_comb begin
		ey_sum = 59'(pc_s2) - 59'(ps_s2) + 59'sd536870912;
		ey_shr = ey_sum >>> 30;
		if (ey_shr > ssl_pkg::EY_MAX) ey_c = 24'sh7FFFFF;
		else if (ey_shr < ssl_pkg::EY_MIN) ey_c = -24'sh800000;
		else ey_c = ey_shr[23:0];
		num_c = $signed({1'b0, gain}) * ey_s3;
	end

	// middle stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= sc_v_s[N];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// middle stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			sin_s1 <= sc_it_s[N].neg ? -sc_y_s[N] : sc_y_s[N];
			cos_s1 <= sc_it_s[N].neg ? -sc_x_s[N] : sc_x_s[N];
			dx_s1  <= sc_it_s[N].dx;
			dy_s1  <= sc_it_s[N].dy;
			eh_s1  <= sc_it_s[N].eh;
			spd_s1 <= sc_it_s[N].spd;
			pc_s2  <= dy_s1 * cos_s1;
			ps_s2  <= dx_s1 * sin_s1;
			eh_s2  <= eh_s1;
			spd_s2 <= spd_s1;
			ey_s3  <= ey_c;
			eh_s3  <= eh_s2;
			spd_s3 <= spd_s2;
			num_s4 <= num_c;
			eh_s4  <= eh_s3;
			spd_s4 <= spd_s3;
		end
	end

	// atan2 cordic entry
	assign at_v_s[0]  = v_s4;
	assign at_x_s[0]  = 42'($signed({1'b0, spd_s4, 12'd0}));
	assign at_y_s[0]  = 42'(num_s4);
	assign at_z_s[0]  = '0;
	assign at_eh_s[0] = eh_s4;
	assign at_d0_s[0] = (spd_s4 == '0);
	assign at_np_s[0] = (num_s4 > 0);
	assign at_nn_s[0] = (num_s4 < 0);

	for (genvar g = 0; g < N; g++) begin : g_at
		localparam logic signed [27:0] ATAN_C = $signed({4'd0, ssl_pkg::atan_q24(g)});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				at_v_s[g+1] <= 1'b0;
			end else if (en) begin
				at_v_s[g+1] <= at_v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				at_eh_s[g+1] <= at_eh_s[g];
				at_d0_s[g+1] <= at_d0_s[g];
				at_np_s[g+1] <= at_np_s[g];
				at_nn_s[g+1] <= at_nn_s[g];
				if (at_y_s[g] > 0) begin
					at_x_s[g+1] <= at_x_s[g] + (at_y_s[g] >>> g);
					at_y_s[g+1] <= at_y_s[g] - (at_x_s[g] >>> g);
					at_z_s[g+1] <= at_z_s[g] + ATAN_C;
				end else begin
					at_x_s[g+1] <= at_x_s[g] - (at_y_s[g] >>> g);
					at_y_s[g+1] <= at_y_s[g] + (at_x_s[g] >>> g);
					at_z_s[g+1] <= at_z_s[g] - ATAN_C;
				end
			end
		end
	end

	// zero speed override, rounding, command sum and clamp
	always_comb begin
		if (at_d0_s[N]) begin
			if (at_np_s[N]) at_fin = ssl_pkg::HALF_PI_Q24;
			else if (at_nn_s[N]) at_fin = -ssl_pkg::HALF_PI_Q24;
			else at_fin = '0;
		end else begin
			at_fin = at_z_s[N];
		end
		at_rnd    = (29'(at_fin) + 29'sd1024) >>> 11;
		steer_raw = 19'(at_eh_s[N]) + 19'(at_rnd);
		lim19     = $signed({4'd0, limit});
		if (steer_raw > lim19) begin
			steer_c = lim19[15:0];
			clamp_c = 1'b1;
		end else if (steer_raw < -lim19) begin
			steer_c = 16'(-lim19);
			clamp_c = 1'b1;
		end else begin
			steer_c = steer_raw[15:0];
			clamp_c = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= at_v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			steer_q <= steer_c;
			clamp_q <= clamp_c;
		end
	end

	a_clamp_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && clamp_q |->
		(steer_q == $signed({1'b0, limit}) || steer_q == -$signed({1'b0, limit})))
		else $error("clamped result not at the steering limit");
	a_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (steer_q <= $signed({1'b0, limit}) &&
		steer_q >= -$signed({1'b0, limit})))
		else $error("steering result beyond limit");

endmodule

// ===== hdl/stanley_steering_law.sv =====
// top level of the stanley steering law block
// depends on ssl_pkg, ssl_if, ssl_front, ssl_queue and ssl_back
`timescale 1ns / 1ps

// Usage:
// pose is a valid/ready sink carrying one reference point, the vehicle
// pose and speed per transaction; steer is a valid/ready source carrying
// the clamped steering angle and a flag set when the clamp acted.
// One result per pose, in order.
// Throughput: one transaction per cycle unless steer.ready stalls; the
// sin/cos and atan2 cordics are fully pipelined, one iteration per stage.
// Path: front register, queue, sin/cos cordic stages, sign fix, product,
// error and numerator stages, atan2 cordic stages and result register.
// Configuration: cfg_we with cfg_index 0 writes the cross-track gain
// (unsigned Q4.12), index 1 the steering limit (low 15 bits, Q2.13);
// write only while the block is empty.
// Reset: arst_n clears all valids and the queue, gain returns to 0.8 and
// the limit to 1.0 rad.
// Stall: when a result is held and steer.ready is low the whole back
// pipeline holds; the queue and front register keep taking poses until
// the queue fills, then pose.ready drops.

module stanley_steering_law #(
	parameter int CORDIC_ITERATIONS = ssl_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ssl_pose_if.sink                       pose,
	ssl_steer_if.source                    steer,
	input  logic                           cfg_we,
	input  logic [ssl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssl_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [15:0]            gain_q;
	logic [14:0]            limit_q;
	logic                   push;
	logic                   pop;
	ssl_pkg::ssl_item_t     push_item;
	ssl_pkg::ssl_item_t     head;
	ssl_pkg::ssl_q_status_t qstat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= ssl_pkg::GAIN_RESET;
			limit_q <= ssl_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ssl_pkg::CFG_GAIN:  gain_q  <= cfg_data;
				ssl_pkg::CFG_LIMIT: limit_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// front, queue and back
	ssl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pose   (pose),
		.qstat  (qstat),
		.push   (push),
		.item   (push_item)
	);

	ssl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	ssl_back #(
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (!qstat.empty),
		.head    (head),
		.pop     (pop),
		.gain    (gain_q),
		.limit   (limit_q),
		.steer   (steer)
	);

endmodule
